// File: hdl/acpd_pkg.sv
// ----------------------------------------------------------------------------
// acpd_pkg
// shared constants and types of the autocorrelation pitch detector
// ----------------------------------------------------------------------------
package acpd_pkg;

   localparam int MaxWindowDefault  = 4096;
   localparam int SampleBitsDefault = 16;

   // register indexes
   localparam logic [2:0] RegFrameLength  = 3'd0;
   localparam logic [2:0] RegSampleRate   = 3'd1;
   localparam logic [2:0] RegMinLag       = 3'd2;
   localparam logic [2:0] RegMaxLagLimit  = 3'd3;
   localparam logic [2:0] RegThreshold    = 3'd4;

   localparam int CsrDataBits = 31;

   // sine polynomial coefficients, Q30
   localparam logic [31:0] SinC1 = 32'd1686629713;
   localparam logic [31:0] SinC3 = 32'd693598669;
   localparam logic [31:0] SinC5 = 32'd85569306;
   localparam logic [31:0] SinC7 = 32'd5026995;
   localparam logic [31:0] SinC9 = 32'd172272;
   localparam logic [31:0] Q30One = 32'd1073741824;

endpackage

// File: hdl/autocorrelation_pitch_detector_core.sv
// ----------------------------------------------------------------------------
// autocorrelation_pitch_detector_core
// hann-windowed autocorrelation pitch detector, one shared datapath
// ----------------------------------------------------------------------------
// Usage: raise start with req_sample while busy is low to hand in one sample
// transaction; busy rises the next cycle. Each sample is windowed on one
// shared 33x33 multiplier and one shared restoring divider: the 32-step
// phase division, six polynomial products, a spare scale state, the
// squaring, the sample product and the store write. busy stays high until
// the sample is stored, so the block takes no new sample before that.
// After the last sample of a frame the block sweeps lags min_lag (1 if zero)
// to one below the smaller of N/2 and max_lag_limit; each lag sums (N-lag)
// products (read, read, multiply, add), then the 64-step mean division and
// the compare. A last lag-set state ends the sweep, a valid pitch adds the
// 28-step frequency division, the out state registers the result, and
// rsp_valid shows the result transaction for one cycle as busy drops; the
// receiver cannot stall it. Reset clears the sequencer and frame position;
// configuration goes back to its defaults. The sample store holds no reset
// value: every entry read in a frame was written earlier in that frame.
// ----------------------------------------------------------------------------
module autocorrelation_pitch_detector_core #(
   parameter int MAX_WINDOW  = acpd_pkg::MaxWindowDefault,
   parameter int SAMPLE_BITS = acpd_pkg::SampleBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                        csr_write,
   input  logic [2:0]                  csr_index,
   input  logic [acpd_pkg::CsrDataBits-1:0] csr_data,
   output logic                        rsp_valid,
   output logic                        rsp_valid_res,
   output logic [11:0]                 rsp_best_lag,
   output logic [30:0]                 rsp_peak_correlation,
   output logic [21:0]                 rsp_frequency_q4
);
   import acpd_pkg::*;

   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = AW + 1;
   localparam int SW = SAMPLE_BITS;
   localparam int HALF = MAX_WINDOW / 2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PDIV, ST_POLY, ST_SCALE, ST_WSQ, ST_WMUL, ST_WRITE,
      ST_LAGSET, ST_MAC, ST_MACEND, ST_MDIV, ST_CMP, ST_FDIV, ST_OUT
   } state_type;

   // configuration
   logic [12:0] frame_length_ff;
   logic [17:0] sample_rate_ff;
   logic [11:0] min_lag_ff, max_lag_limit_ff;
   logic [30:0] corr_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= 13'd2048;
         sample_rate_ff    <= 18'd48000;
         min_lag_ff        <= 12'd48;
         max_lag_limit_ff  <= 12'd960;
         corr_threshold_ff <= 31'd107374182;
      end else if (csr_write) begin
         unique case (csr_index)
            RegFrameLength: frame_length_ff   <= csr_data[12:0];
            RegSampleRate:  sample_rate_ff    <= csr_data[17:0];
            RegMinLag:      min_lag_ff        <= csr_data[11:0];
            RegMaxLagLimit: max_lag_limit_ff  <= csr_data[11:0];
            RegThreshold:   corr_threshold_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // clamped frame size
   logic [CW-1:0] n_size;
   always_comb begin
      if (frame_length_ff < 13'd2)
         n_size = CW'(2);
      else if (32'(frame_length_ff) > 32'(MAX_WINDOW))
         n_size = CW'(MAX_WINDOW);
      else
         n_size = CW'(frame_length_ff);
   end

   // sample store
   logic signed [SW-1:0] store_mem [MAX_WINDOW];
   logic [AW-1:0]        rd_addr;
   logic signed [SW-1:0] rd_data_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [SW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_data_ff <= store_mem[rd_addr];
   end

   // shared multiplier, 33x33 signed, registered product
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p_ff;
   always_ff @(posedge clock) mul_p_ff <= mul_a * mul_b;

   // shared restoring divider, one quotient bit a cycle
   logic [63:0] div_num_ff;
   logic [31:0] div_den_ff;
   logic [63:0] div_quo_ff;
   logic [32:0] div_rem_ff;
   logic [6:0]  div_cnt_ff;
   logic [33:0] div_trial;
   assign div_trial = {div_rem_ff, div_num_ff[63]} - {2'b0, div_den_ff};

   state_type     state_ff;
   logic [CW-1:0] count_ff;       // position of the next sample
   logic [AW-1:0] idx_ff;
   logic signed [SW-1:0] smp_ff;
   logic [2:0]    step_ff;
   logic          phase_ff;
   logic [31:0]   t_ff, t2_ff, acc_ff;
   logic [15:0]   w15_ff;
   logic [12:0]   lag_ff, hi_ff;
   logic [CW-1:0] k_ff, cnt_ff;
   logic signed [63:0] sum_ff;
   logic          sum_neg_ff;
   logic [1:0]    pipe_ff;
   logic [30:0]   best_ff;
   logic [11:0]   blag_ff;
   logic          frame_end;

   logic [12:0] lo_lag, hi_lag;
   always_comb begin
      hi_lag = 13'(n_size >> 1);
      if (32'(hi_lag) > 32'(HALF)) hi_lag = 13'(HALF);
      if (hi_lag > {1'b0, max_lag_limit_ff}) hi_lag = {1'b0, max_lag_limit_ff};
      lo_lag = (min_lag_ff == 12'd0) ? 13'd1 : {1'b0, min_lag_ff};
   end

   // store addresses
   always_comb begin
      if (state_ff == ST_MAC && pipe_ff[0])
         rd_addr = AW'(k_ff + CW'(lag_ff));
      else
         rd_addr = AW'(k_ff);
   end
   assign wr_en   = (state_ff == ST_WRITE);
   assign wr_addr = idx_ff;

   // windowed sample: floor((prod + 2^14) / 2^15)
   logic signed [65:0] wsum;
   assign wsum    = mul_p_ff + 66'sd16384;
   assign wr_data = SW'(wsum >>> 15);

   // multiplier operand selection
   logic signed [SW-1:0] k_sample_ff;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_POLY: begin
            if (step_ff == 3'd0) begin
               mul_a = {1'b0, t_ff};   mul_b = {1'b0, t_ff};
            end else if (step_ff == 3'd6) begin
               mul_a = {1'b0, acc_ff}; mul_b = {1'b0, t_ff};
            end else begin
               mul_a = {1'b0, acc_ff}; mul_b = {1'b0, t2_ff};
            end
         end
         ST_WSQ: begin
            mul_a = {1'b0, acc_ff}; mul_b = {1'b0, acc_ff};
         end
         ST_WMUL: begin
            mul_a = 33'(smp_ff); mul_b = {17'b0, w15_ff};
         end
         ST_MAC: begin
            mul_a = 33'(k_sample_ff); mul_b = 33'(rd_data_ff);
         end
         default: ;
      endcase
   end

   logic [63:0] prod_u;
   assign prod_u = mul_p_ff[63:0];

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         rsp_valid <= (state_ff == ST_OUT);
         // divider iteration runs in its own states
         if (state_ff == ST_PDIV || state_ff == ST_MDIV || state_ff == ST_FDIV) begin
            if (div_cnt_ff != 7'd0) begin
               if (!div_trial[33]) begin
                  div_rem_ff <= div_trial[32:0];
                  div_quo_ff <= {div_quo_ff[62:0], 1'b1};
               end else begin
                  div_rem_ff <= {div_rem_ff[31:0], div_num_ff[63]};
                  div_quo_ff <= {div_quo_ff[62:0], 1'b0};
               end
               div_num_ff <= {div_num_ff[62:0], 1'b0};
               div_cnt_ff <= div_cnt_ff - 7'd1;
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  smp_ff <= req_sample;
                  if (count_ff >= n_size) begin
                     idx_ff   <= '0;
                     count_ff <= '0;
                  end else begin
                     idx_ff <= AW'(count_ff);
                  end
                  div_num_ff <= (count_ff >= n_size) ? 64'd0
                                : (64'(count_ff) << 16) << 32;
                  div_den_ff <= 32'(n_size - CW'(1));
                  div_rem_ff <= '0;
                  div_quo_ff <= '0;
                  div_cnt_ff <= 7'd32;
                  state_ff   <= ST_PDIV;
               end
            end
            ST_PDIV: begin
               if (div_cnt_ff == 7'd0) begin
                  // fold p to x and form t in Q30
                  logic [31:0] p, x;
                  p = (div_quo_ff[31:0] > 32'd65536) ? 32'd65536 : div_quo_ff[31:0];
                  x = (p <= 32'd32768) ? p : 32'd65536 - p;
                  t_ff     <= x << 15;
                  acc_ff   <= SinC9;
                  step_ff  <= 3'd0;
                  phase_ff <= 1'b0;
                  state_ff <= ST_POLY;
               end
            end
            ST_POLY: begin
               // even phase issues the product, odd phase consumes it
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  unique case (step_ff)
                     3'd0: t2_ff  <= prod_u[61:30];
                     3'd1: acc_ff <= SinC7 - prod_u[61:30];
                     3'd2: acc_ff <= SinC5 - prod_u[61:30];
                     3'd3: acc_ff <= SinC3 - prod_u[61:30];
                     3'd4: acc_ff <= SinC1 - prod_u[61:30];
                     default: acc_ff <= (prod_u[63:30] > 34'(Q30One)) ? Q30One
                                        : prod_u[61:30];
                  endcase
                  if (step_ff == 3'd6) begin
                     state_ff <= ST_SCALE;
                  end else begin
                     step_ff <= (step_ff == 3'd4) ? 3'd6 : step_ff + 3'd1;
                  end
               end
            end
            ST_SCALE: begin
               state_ff <= ST_WSQ;
            end
            ST_WSQ: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  // w = s*s >> 30, w15 = (w + 2^14) >> 15
                  w15_ff   <= 16'((prod_u[61:30] + 32'd16384) >> 15);
                  state_ff <= ST_WMUL;
               end
            end
            ST_WMUL: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (count_ff + CW'(1) >= n_size) begin
                  count_ff <= '0;
                  best_ff  <= '0;
                  blag_ff  <= '0;
                  lag_ff   <= lo_lag;
                  hi_ff    <= hi_lag;
                  state_ff <= ST_LAGSET;
               end else begin
                  count_ff <= count_ff + CW'(1);
                  state_ff <= ST_IDLE;
               end
            end
            ST_LAGSET: begin
               if (lag_ff >= hi_ff) begin
                  if (blag_ff != 12'd0 && best_ff > corr_threshold_ff) begin
                     // top 28 numerator bits hold sample_rate * 16
                     div_num_ff <= {46'b0, sample_rate_ff} << 40;
                     div_den_ff <= {20'b0, blag_ff};
                     div_rem_ff <= '0;
                     div_quo_ff <= '0;
                     div_cnt_ff <= 7'd28;
                     state_ff   <= ST_FDIV;
                  end else begin
                     div_quo_ff <= '0;
                     state_ff   <= ST_OUT;
                  end
               end else begin
                  k_ff     <= '0;
                  cnt_ff   <= CW'(13'(n_size) - lag_ff);
                  sum_ff   <= '0;
                  pipe_ff  <= 2'd0;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               // step 0 reads x[k], step 1 reads x[k+lag], step 2 multiplies, step 3 adds
               pipe_ff <= pipe_ff + 2'd1;
               if (pipe_ff == 2'd1) k_sample_ff <= rd_data_ff;
               if (pipe_ff == 2'd3) begin
                  sum_ff  <= sum_ff + 64'(mul_p_ff);
                  k_ff    <= k_ff + CW'(1);
                  if (k_ff + CW'(1) >= cnt_ff) state_ff <= ST_MACEND;
               end
            end
            ST_MACEND: begin
               // magnitude division; the sign is kept and negative sums fail the compare
               sum_neg_ff <= sum_ff[63];
               div_num_ff <= sum_ff[63] ? 64'(-sum_ff) : 64'(sum_ff);
               div_den_ff <= 32'(cnt_ff);
               div_rem_ff <= '0;
               div_quo_ff <= '0;
               div_cnt_ff <= 7'd64;
               state_ff   <= ST_MDIV;
            end
            ST_MDIV: begin
               if (div_cnt_ff == 7'd0) state_ff <= ST_CMP;
            end
            ST_CMP: begin
               if (!sum_neg_ff && div_quo_ff != 64'd0 &&
                   div_quo_ff > {33'b0, best_ff}) begin
                  best_ff <= (div_quo_ff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF
                             : div_quo_ff[30:0];
                  blag_ff <= lag_ff[11:0];
               end
               lag_ff   <= lag_ff + 13'd1;
               state_ff <= ST_LAGSET;
            end
            ST_FDIV: begin
               if (div_cnt_ff == 7'd0) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               rsp_best_lag         <= blag_ff;
               rsp_peak_correlation <= best_ff;
               rsp_valid_res        <= (blag_ff != 12'd0) && (best_ff > corr_threshold_ff);
               rsp_frequency_q4     <= div_quo_ff[21:0];
               state_ff             <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign frame_end = (state_ff == ST_OUT);

   // checks
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(frame_end))
      else $error("result without frame end");
   a_freq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> rsp_frequency_q4 == 22'd0)
      else $error("frequency on invalid result");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rsp_valid) |-> count_ff == '0)
      else $error("frame position not cleared");

endmodule
